// ----- hdl/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional insert/delete list package
// Shared sizes, action and status codes, and payload types of the list core.
// ----------------------------------------------------------------------------
package pidl_pkg;

  // Number of entries the list can hold.
  localparam int unsigned Capacity = 16;

  // Entry count width (holds 0 .. Capacity) and slot index width.
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;

  // Fixed field widths.
  localparam int unsigned ActW = 3;
  localparam int unsigned PosW = 5;
  localparam int unsigned ValW = 32;
  localparam int unsigned StW  = 2;

  // Width used to compare a position against the count without overflow.
  localparam int unsigned CmpW = ((PosW > CntW) ? PosW : CntW) + 1;

  typedef enum logic [ActW-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_DUMP      = 3'd6
  } action_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef logic signed [ValW-1:0] value_t;
  typedef logic [CntW-1:0]        count_t;
  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [PosW-1:0]        pos_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    value_t          value;
    pos_t            position;
  } req_t;

endpackage

// ----- hdl/pidl_req_if.sv -----
// ----------------------------------------------------------------------------
// List request channel
// Valid/ready channel that carries one list action request.
// ----------------------------------------------------------------------------
interface pidl_req_if;
  logic                        valid;
  logic                        ready;
  logic [pidl_pkg::ActW-1:0]   action;
  pidl_pkg::value_t            value;
  pidl_pkg::pos_t              position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

// ----- hdl/pidl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// List response channel
// Valid/ready channel that carries one result of a list action.
// ----------------------------------------------------------------------------
interface pidl_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pidl_pkg::StW-1:0]   status;
  pidl_pkg::count_t           entry_count;
  pidl_pkg::value_t           entry_value;
  logic                       entry_valid;
  logic                       last_result;

  modport source (output valid, status, entry_count, entry_value, entry_valid,
                  last_result, input ready);
  modport sink   (input valid, status, entry_count, entry_value, entry_valid,
                  last_result, output ready);
endinterface

// ----- hdl/positional_insert_delete_list_core.sv -----
// ----------------------------------------------------------------------------
// Positional insert/delete list core
// Ordered list of signed 32-bit values with insert, delete and dump requests.
// ----------------------------------------------------------------------------
// The core keeps up to pidl_pkg::Capacity entries in a row of registers. A
// request is first captured in an input register; from there, once the
// output register is free, its action is carried out and its result is
// written to the output register. Insert and delete requests shift every
// entry behind the affected slot at once, so one such request can be
// accepted every cycle when the response side is not stalled. A dump
// streams one entry per cycle, while the response side is not stalled,
// through the single output register and the one read port on the entry
// row; the next request is not accepted until the final entry has been
// written to the output register. Every request that is not a dump returns
// exactly one result carrying the status and the count after the action.
// The entry row has no reset; only the count and the control registers
// are cleared, and no entry at or above the count is ever read.
module positional_insert_delete_list_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  pidl_req_if.sink          req_i,
  pidl_rsp_if.source        rsp_o
);

  // Input register: holds the request being worked on.
  pidl_pkg::req_t   req_q;
  logic             req_valid_q, req_valid_d;

  // List state.
  pidl_pkg::value_t entries_q [pidl_pkg::Capacity];
  pidl_pkg::value_t entries_d [pidl_pkg::Capacity];
  pidl_pkg::count_t count_q, count_d;

  // Read pointer while a dump streams out.
  pidl_pkg::idx_t   dump_idx_q, dump_idx_d;

  // Output register.
  logic             rsp_valid_q;
  pidl_pkg::status_e rsp_status_q, rsp_status_d;
  pidl_pkg::count_t rsp_count_q;
  pidl_pkg::value_t rsp_value_q, rsp_value_d;
  logic             rsp_entry_valid_q, rsp_entry_valid_d;
  logic             rsp_last_q, rsp_last_d;

  // Control.
  logic             out_free;
  logic             fire;
  logic             done;
  logic             req_accept;
  logic             ins, del;
  logic             do_ins, do_del;
  pidl_pkg::count_t slot;
  logic             full, empty;
  logic             dump_last;
  logic [pidl_pkg::CmpW-1:0] pos_ext, cnt_ext;

  // The output register can take a new result when it is empty or its
  // current result leaves in this cycle.
  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign fire       = req_valid_q && out_free;
  assign req_accept = req_i.valid && req_i.ready;
  assign req_i.ready = !req_valid_q || done;

  assign full    = (count_q == pidl_pkg::CntW'(pidl_pkg::Capacity));
  assign empty   = (count_q == '0);
  assign pos_ext = pidl_pkg::CmpW'(req_q.position);
  assign cnt_ext = pidl_pkg::CmpW'(count_q);

  // The dump is on its final entry when the next index would reach count.
  assign dump_last = (pidl_pkg::CntW'(dump_idx_q) + pidl_pkg::CntW'(1)) == count_q;

  // Decode the held request into a status, a shift and a result.
  always_comb begin
    rsp_status_d      = pidl_pkg::ST_OK;
    rsp_value_d       = '0;
    rsp_entry_valid_d = 1'b0;
    rsp_last_d        = 1'b1;
    ins               = 1'b0;
    del               = 1'b0;
    slot              = '0;
    done              = fire;
    dump_idx_d        = dump_idx_q;

    unique case (pidl_pkg::action_e'(req_q.action))
      pidl_pkg::ACT_INS_FRONT: begin
        if (full) begin
          rsp_status_d = pidl_pkg::ST_FULL;
        end else begin
          ins  = 1'b1;
          slot = '0;
        end
      end
      pidl_pkg::ACT_INS_BACK: begin
        if (full) begin
          rsp_status_d = pidl_pkg::ST_FULL;
        end else begin
          ins  = 1'b1;
          slot = count_q;
        end
      end
      pidl_pkg::ACT_INS_POS: begin
        // The position check comes before the full check.
        if (pos_ext == '0 || pos_ext > cnt_ext + pidl_pkg::CmpW'(1)) begin
          rsp_status_d = pidl_pkg::ST_INVALID;
        end else if (full) begin
          rsp_status_d = pidl_pkg::ST_FULL;
        end else begin
          ins  = 1'b1;
          slot = pidl_pkg::CntW'(pos_ext - pidl_pkg::CmpW'(1));
        end
      end
      pidl_pkg::ACT_DEL_FRONT: begin
        if (empty) begin
          rsp_status_d = pidl_pkg::ST_EMPTY;
        end else begin
          del  = 1'b1;
          slot = '0;
        end
      end
      pidl_pkg::ACT_DEL_BACK: begin
        if (empty) begin
          rsp_status_d = pidl_pkg::ST_EMPTY;
        end else begin
          del  = 1'b1;
          slot = count_q - pidl_pkg::CntW'(1);
        end
      end
      pidl_pkg::ACT_DEL_POS: begin
        if (empty) begin
          rsp_status_d = pidl_pkg::ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          rsp_status_d = pidl_pkg::ST_INVALID;
        end else begin
          del  = 1'b1;
          slot = pidl_pkg::CntW'(pos_ext - pidl_pkg::CmpW'(1));
        end
      end
      pidl_pkg::ACT_DUMP: begin
        if (empty) begin
          rsp_status_d = pidl_pkg::ST_EMPTY;
        end else begin
          // Stream one entry per cycle while the output register is free; the request stays held until the
          // final entry has been written to the output register.
          rsp_value_d       = entries_q[dump_idx_q];
          rsp_entry_valid_d = 1'b1;
          rsp_last_d        = dump_last;
          done              = fire && dump_last;
          if (fire) begin
            dump_idx_d = dump_last ? '0 : dump_idx_q + pidl_pkg::IdxW'(1);
          end
        end
      end
      default: begin
        rsp_status_d = pidl_pkg::ST_INVALID;
      end
    endcase
  end

  assign do_ins = fire && ins;
  assign do_del = fire && del;

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + pidl_pkg::CntW'(1);
    end else if (do_del) begin
      count_d = count_q - pidl_pkg::CntW'(1);
    end
  end

  // Each cell picks its own value, the request value, its left neighbor or its right neighbor.
  for (genvar g = 0; g < pidl_pkg::Capacity; g++) begin : g_cell
    pidl_pkg::value_t prev_val, next_val;

    if (g == 0) begin : g_first
      assign prev_val = entries_q[g];
    end else begin : g_prev
      assign prev_val = entries_q[g-1];
    end

    if (g == pidl_pkg::Capacity - 1) begin : g_last
      assign next_val = entries_q[g];
    end else begin : g_next
      assign next_val = entries_q[g+1];
    end

    always_comb begin
      entries_d[g] = entries_q[g];
      if (do_ins) begin
        if (pidl_pkg::CntW'(g) == slot) begin
          entries_d[g] = req_q.value;
        end else if (pidl_pkg::CntW'(g) > slot) begin
          entries_d[g] = prev_val;
        end
      end else if (do_del) begin
        if (pidl_pkg::CntW'(g) >= slot) begin
          entries_d[g] = next_val;
        end
      end
    end
  end

  always_comb begin
    req_valid_d = req_valid_q;
    if (req_accept) begin
      req_valid_d = 1'b1;
    end else if (done) begin
      req_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      count_q     <= '0;
      dump_idx_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      req_q.action   <= req_i.action;
      req_q.value    <= req_i.value;
      req_q.position <= req_i.position;
    end
    entries_q <= entries_d;
    if (fire) begin
      rsp_status_q      <= rsp_status_d;
      rsp_count_q       <= count_d;
      rsp_value_q       <= rsp_value_d;
      rsp_entry_valid_q <= rsp_entry_valid_d;
      rsp_last_q        <= rsp_last_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.entry_value = rsp_value_q;
  assign rsp_o.entry_valid = rsp_entry_valid_q;
  assign rsp_o.last_result = rsp_last_q;

`ifndef SYNTHESIS
  // The count never goes past the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pidl_pkg::CntW'(pidl_pkg::Capacity))
    else $error("list count exceeds capacity");

  // The count moves by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == $past(count_q) + pidl_pkg::CntW'(1) ||
       count_q == $past(count_q) - pidl_pkg::CntW'(1)))
    else $error("list count jumped by more than one");

  // While a dump streams, the read pointer stays below the count.
  a_dump_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && req_q.action == pidl_pkg::ACT_DUMP && count_q != '0 |->
      pidl_pkg::CntW'(dump_idx_q) < count_q)
    else $error("dump pointer beyond list end");

  // An emitted entry always comes with an ok status and a non-zero count.
  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_entry_valid_q |->
      rsp_status_q == pidl_pkg::ST_OK && rsp_count_q != '0)
    else $error("entry result with bad status or zero count");
`endif

endmodule
